[design/nmea_sentence_checker_defines.svh]
// Assertion macros shared by the NMEA sentence checker RTL.
`ifndef NMEA_SENTENCE_CHECKER_DEFINES_SVH
`define NMEA_SENTENCE_CHECKER_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define NSC_ASSERT_CLK(label, clock, resetn, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) prop) else $error(msg);

// Same, on the block's own clk and rst_n.
`define NSC_ASSERT(label, prop, msg) \
    `NSC_ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

[design/nsc_pkg.sv]
// Package: types and constants of the NMEA sentence checker.
`timescale 1ns / 1ps

package nsc_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_A      = 8'h41;

    localparam int NAME_COUNT = 5;
    localparam int NAME_CHARS = 5;

    localparam logic [7:0] NAME_END_POS    = 8'd6;
    localparam logic [7:0] GSV_PART_OFFSET = 8'd9;
    localparam logic [7:0] STATUS_OFFSET   = 8'd18;
    localparam logic [7:0] POS_MAX         = 8'd255;
    localparam logic [7:0] MAX_LEN_RESET   = 8'd83;

    // Sentence type codes
    localparam logic [2:0] TYPE_UNKNOWN = 3'd0;
    localparam logic [2:0] TYPE_RMC     = 3'd1;
    localparam logic [2:0] TYPE_VTG     = 3'd2;
    localparam logic [2:0] TYPE_GGA     = 3'd3;
    localparam logic [2:0] TYPE_GSA     = 3'd4;
    localparam logic [2:0] TYPE_GSV     = 3'd5;

    // Config register index (byte address / 4)
    localparam logic REG_MAX_LEN = 1'b0;

    // Name table: [name][char], names in order RMC VTG GGA GSA GSV
    localparam logic [NAME_COUNT-1:0][NAME_CHARS-1:0][7:0] NAME_TAB = '{
        '{8'h56, 8'h53, 8'h47, 8'h50, 8'h47},  // GPGSV (index 4)
        '{8'h41, 8'h53, 8'h47, 8'h50, 8'h47},  // GPGSA
        '{8'h41, 8'h47, 8'h47, 8'h50, 8'h47},  // GPGGA
        '{8'h47, 8'h54, 8'h56, 8'h50, 8'h47},  // GPVTG
        '{8'h43, 8'h4D, 8'h52, 8'h50, 8'h47}   // GPRMC (index 0)
    };

    typedef enum logic [1:0] {
        PH_BEFORE_STAR,
        PH_HEX_HI,
        PH_HEX_LO,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } nsc_byte_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] sentence_type;
        logic       checksum_ok;
        logic [3:0] gsv_part;
        logic       fix_valid;
        logic [7:0] sentence_length;
        logic       too_long;
    } nsc_result_t;

    // Uppercase hex digit value; anything else reads as 0
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c[3:0];
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

[design/nsc_in_stage.sv]
// Input register: holds one received byte until the parser takes it.
`timescale 1ns / 1ps

module nsc_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          rx_byte,
    input  logic                advance,
    output nsc_pkg::nsc_byte_t  held
);

    logic       vld_reg;
    logic       vld_next;
    logic [7:0] data_reg;
    logic       accept;

    assign in_stall = vld_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (accept)
        begin
            vld_next = 1'b1;
        end
        else if (advance)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= rx_byte;
        end
    end

    assign held.valid = vld_reg;
    assign held.data  = data_reg;

endmodule

[design/nsc_parser.sv]
// Sentence parser: per-byte state update and result build.
`timescale 1ns / 1ps
`include "nmea_sentence_checker_defines.svh"

module nsc_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic [7:0]           rx_data,
    input  logic [7:0]           max_len,
    output nsc_pkg::nsc_result_t result
);

    logic                                in_sent_reg, in_sent_next;
    logic [7:0]                          pos_reg, pos_next;
    logic [7:0]                          xor_reg, xor_next;
    logic [nsc_pkg::NAME_COUNT-1:0]      cand_reg, cand_next;
    nsc_pkg::phase_t                     phase_reg, phase_next;
    logic [7:0]                          rsum_reg, rsum_next;
    logic [3:0]                          part_reg, part_next;
    logic                                status_reg, status_next;
    logic [2:0]                          col;
    logic [2:0]                          kind;

    assign col = pos_reg[2:0] - 3'd1;

    // Next state
    always_comb
    begin
        in_sent_next = in_sent_reg;
        pos_next     = pos_reg;
        xor_next     = xor_reg;
        cand_next    = cand_reg;
        phase_next   = phase_reg;
        rsum_next    = rsum_reg;
        part_next    = part_reg;
        status_next  = status_reg;
        if (advance)
        begin
            if (rx_data == nsc_pkg::CH_DOLLAR)
            begin
                in_sent_next = 1'b1;
                pos_next     = 8'd1;
                xor_next     = 8'd0;
                cand_next    = '1;
                phase_next   = nsc_pkg::PH_BEFORE_STAR;
                rsum_next    = 8'd0;
                part_next    = 4'd0;
                status_next  = 1'b0;
            end
            else if (in_sent_reg)
            begin
                if (rx_data == nsc_pkg::CH_LF)
                begin
                    in_sent_next = 1'b0;
                end
                else
                begin
                    if (pos_reg >= 8'd1 && pos_reg < nsc_pkg::NAME_END_POS)
                    begin
                        for (int k = 0; k < nsc_pkg::NAME_COUNT; k++)
                        begin
                            if (rx_data != nsc_pkg::NAME_TAB[k][col])
                            begin
                                cand_next[k] = 1'b0;
                            end
                        end
                    end
                    if (pos_reg == nsc_pkg::GSV_PART_OFFSET)
                    begin
                        part_next = (rx_data >= 8'h30 && rx_data <= 8'h39) ?
                                    rx_data[3:0] : 4'd0;
                    end
                    if (pos_reg == nsc_pkg::STATUS_OFFSET)
                    begin
                        status_next = (rx_data == nsc_pkg::CH_A);
                    end
                    unique case (phase_reg)
                        nsc_pkg::PH_BEFORE_STAR:
                        begin
                            if (rx_data == nsc_pkg::CH_STAR)
                            begin
                                phase_next = nsc_pkg::PH_HEX_HI;
                            end
                            else
                            begin
                                xor_next = xor_reg ^ rx_data;
                            end
                        end
                        nsc_pkg::PH_HEX_HI:
                        begin
                            rsum_next  = {nsc_pkg::hex_value(rx_data), 4'd0};
                            phase_next = nsc_pkg::PH_HEX_LO;
                        end
                        nsc_pkg::PH_HEX_LO:
                        begin
                            rsum_next  = {rsum_reg[7:4], nsc_pkg::hex_value(rx_data)};
                            phase_next = nsc_pkg::PH_DONE;
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                    pos_next = (pos_reg != nsc_pkg::POS_MAX) ? pos_reg + 8'd1 : pos_reg;
                end
            end
        end
    end

    // Result on newline inside a sentence; lowest matching name wins
    always_comb
    begin
        kind = nsc_pkg::TYPE_UNKNOWN;
        if (pos_reg >= nsc_pkg::NAME_END_POS)
        begin
            for (int k = nsc_pkg::NAME_COUNT - 1; k >= 0; k--)
            begin
                if (cand_reg[k])
                begin
                    kind = 3'(k + 1);
                end
            end
        end
        result.valid           = advance && in_sent_reg && (rx_data == nsc_pkg::CH_LF);
        result.sentence_type   = kind;
        result.checksum_ok     = (phase_reg != nsc_pkg::PH_BEFORE_STAR) &&
                                 (xor_reg == rsum_reg);
        result.gsv_part        = (kind == nsc_pkg::TYPE_GSV) ? part_reg : 4'd0;
        result.fix_valid       = (kind == nsc_pkg::TYPE_RMC) && status_reg;
        result.sentence_length = pos_reg;
        result.too_long        = (pos_reg >= max_len);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sent_reg <= 1'b0;
            pos_reg     <= 8'd0;
            xor_reg     <= 8'd0;
            cand_reg    <= '1;
            phase_reg   <= nsc_pkg::PH_BEFORE_STAR;
            rsum_reg    <= 8'd0;
            part_reg    <= 4'd0;
            status_reg  <= 1'b0;
        end
        else
        begin
            in_sent_reg <= in_sent_next;
            pos_reg     <= pos_next;
            xor_reg     <= xor_next;
            cand_reg    <= cand_next;
            phase_reg   <= phase_next;
            rsum_reg    <= rsum_next;
            part_reg    <= part_next;
            status_reg  <= status_next;
        end
    end

    `NSC_ASSERT(a_pos_in_sentence, in_sent_reg |-> pos_reg != 8'd0, "position zero inside sentence")

endmodule

[design/nsc_out_stage.sv]
// Result register: holds one result until the consumer takes it.
`timescale 1ns / 1ps

module nsc_out_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  nsc_pkg::nsc_result_t result,
    output logic                 can_take,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           sentence_type,
    output logic                 checksum_ok,
    output logic [3:0]           gsv_part,
    output logic                 fix_valid,
    output logic [7:0]           sentence_length,
    output logic                 too_long
);

    logic                 vld_reg;
    logic                 vld_next;
    nsc_pkg::nsc_result_t res_reg;

    assign can_take = !vld_reg || !out_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (result.valid)
        begin
            vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            res_reg <= result;
        end
    end

    assign out_valid       = vld_reg;
    assign sentence_type   = res_reg.sentence_type;
    assign checksum_ok     = res_reg.checksum_ok;
    assign gsv_part        = res_reg.gsv_part;
    assign fix_valid       = res_reg.fix_valid;
    assign sentence_length = res_reg.sentence_length;
    assign too_long        = res_reg.too_long;

endmodule

[design/nmea_sentence_checker.sv]
// NMEA sentence checker: APB config register, input register, parser, result register.
// Takes one received character per transfer on the in channel and emits one
// result transfer per '\n' that closes a sentence opened by '$'. A '$' always
// restarts the sentence. The result carries the sentence type (RMC, VTG, GGA,
// GSA, GSV or unknown), whether the XOR over the bytes between '$' and '*'
// matches the two hex digits after '*', the GSV part digit, the RMC fix flag,
// the sentence length (saturating at 255) and an overlong flag against
// max_sentence_length (APB offset 0, reset 83). Throughput is one byte per
// clock while out_stall is low: the whole per-byte update is one short step
// between the input register and the result register, which register a byte
// and its result in that order. While a result sits in the result register
// under out_stall the parser holds its byte; the input register takes at most
// one more byte, then in_stall stays high until that result transfers. Write
// the register only while the block is idle.
`timescale 1ns / 1ps
`include "nmea_sentence_checker_defines.svh"

module nmea_sentence_checker
(
    input  logic        clk,
    input  logic        rst_n,

    // APB config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // Byte input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,

    // Result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  sentence_type,
    output logic        checksum_ok,
    output logic [3:0]  gsv_part,
    output logic        fix_valid,
    output logic [7:0]  sentence_length,
    output logic        too_long
);

    logic                 max_len_sel;
    logic [7:0]           max_len_reg;
    logic [7:0]           max_len_next;
    logic                 cfg_write;
    logic                 can_take;
    logic                 advance;
    nsc_pkg::nsc_byte_t   held;
    nsc_pkg::nsc_result_t result;

    // Config register; a write lands on the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign max_len_sel = (paddr[2] == nsc_pkg::REG_MAX_LEN);

    always_comb
    begin
        max_len_next = max_len_reg;
        if (cfg_write && max_len_sel)
        begin
            max_len_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= nsc_pkg::MAX_LEN_RESET;
        end
        else
        begin
            max_len_reg <= max_len_next;
        end
    end

    assign prdata = max_len_sel ? {24'd0, max_len_reg} : 32'd0;

    // A held byte moves into the parser whenever the result register can take
    // whatever it may produce this cycle.
    assign advance = held.valid && can_take;

    nsc_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .advance  (advance),
        .held     (held)
    );

    nsc_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .rx_data (held.data),
        .max_len (max_len_reg),
        .result  (result)
    );

    nsc_out_stage u_out
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .result          (result),
        .can_take        (can_take),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .sentence_type   (sentence_type),
        .checksum_ok     (checksum_ok),
        .gsv_part        (gsv_part),
        .fix_valid       (fix_valid),
        .sentence_length (sentence_length),
        .too_long        (too_long)
    );

    // A fresh result only follows a byte moving through the parser
    `NSC_ASSERT(a_result_from_advance, $rose(out_valid) |-> $past(advance), "result without byte")
    // Part digit only reported for GSV
    `NSC_ASSERT(a_part_only_gsv, (out_valid && |gsv_part) |-> sentence_type == 3'd5, "part")
    // Fix flag only reported for RMC
    `NSC_ASSERT(a_fix_only_rmc, (out_valid && fix_valid) |-> sentence_type == 3'd1, "fix")

endmodule

[tb/nmea_sentence_checker_tb.sv]
// Testbench for the NMEA sentence checker: directed table, random sentences, scoreboard.
`timescale 1ns / 1ps

module nmea_sentence_checker_tb;

    // APB byte addresses: the length limit register, and one address that decodes to nothing
    localparam logic [2:0] ADDR_MAX_LEN = 3'd0;
    localparam logic [2:0] ADDR_UNUSED  = 3'd4;

    // Settle time after the last report before touching the register (pipe is two deep)
    localparam int PIPE_SETTLE = 4;

    // Random byte budget per length limit setting
    localparam int PHASE_BYTES = 110;

    // One sentence report, field for field as the result ports carry it
    typedef struct packed {
        logic [2:0] sentence_type;
        logic       checksum_ok;
        logic [3:0] gsv_part;
        logic       fix_valid;
        logic [7:0] sentence_length;
        logic       too_long;
    } sentence_report_t;

    // Directed row: head text, then fill copies of 'X', then a line feed
    typedef struct {
        string            head;
        int               fill;
        bit               typed;
        sentence_report_t report;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  sentence_type;
    logic        checksum_ok;
    logic [3:0]  gsv_part;
    logic        fix_valid;
    logic [7:0]  sentence_length;
    logic        too_long;

    nmea_sentence_checker u_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .sentence_type   (sentence_type),
        .checksum_ok     (checksum_ok),
        .gsv_part        (gsv_part),
        .fix_valid       (fix_valid),
        .sentence_length (sentence_length),
        .too_long        (too_long)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Parser shadow state
    // ------------------------------------------------------------------
    string      talker_names [nsc_pkg::NAME_COUNT] =
                    '{"GPRMC", "GPVTG", "GPGGA", "GPGSA", "GPGSV"};
    logic       in_line;
    logic [7:0] line_pos;     // offset of the next byte, '$' is offset 0
    logic [7:0] run_xor;
    logic [4:0] name_hits;    // bit k: talker name k still possible
    nsc_pkg::phase_t sum_phase;
    logic [7:0] got_sum;
    logic [3:0] part_val;
    logic       status_ok;
    logic [7:0] len_limit;

    sentence_report_t report_q [$];   // reports still owed by the block
    logic [7:0]       line_q [$];     // bytes of the sentence being sent

    int errors;
    int bytes_sent;
    int reports_seen;
    int settings_done;
    int burst_left;

    // Uppercase hex digit; anything else counts as zero
    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return 4'(c - "0");
        end
        if (c >= "A" && c <= "F")
        begin
            return 4'(c - "A" + 8'd10);
        end
        return 4'd0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? ("0" + v) : ("A" + v - 8'd10);
    endfunction

    function automatic void start_line();
        in_line   = 1'b1;
        line_pos  = 8'd1;
        run_xor   = 8'd0;
        name_hits = 5'h1F;
        sum_phase = nsc_pkg::PH_BEFORE_STAR;
        got_sum   = 8'd0;
        part_val  = 4'd0;
        status_ok = 1'b0;
    endfunction

    // Advance the shadow parser by one byte; returns 1 when a sentence closes
    function automatic bit parse_byte(input logic [7:0] b, output sentence_report_t rep);
        logic [7:0] pos;
        logic [2:0] kind;
        pos = line_pos;
        rep = '0;
        if (b == nsc_pkg::CH_DOLLAR)
        begin
            start_line();
            return 1'b0;
        end
        if (!in_line)
        begin
            return 1'b0;
        end
        if (b == nsc_pkg::CH_LF)
        begin
            kind = nsc_pkg::TYPE_UNKNOWN;
            if (pos >= nsc_pkg::NAME_END_POS)
            begin
                // walk down so the first name in table order wins
                for (int k = nsc_pkg::NAME_COUNT - 1; k >= 0; k--)
                begin
                    if (name_hits[k])
                    begin
                        kind = 3'(k + 1);
                    end
                end
            end
            rep.sentence_type   = kind;
            rep.checksum_ok     = (sum_phase != nsc_pkg::PH_BEFORE_STAR) &&
                                  (run_xor == got_sum);
            rep.gsv_part        = (kind == nsc_pkg::TYPE_GSV) ? part_val : 4'd0;
            rep.fix_valid       = (kind == nsc_pkg::TYPE_RMC) && status_ok;
            rep.sentence_length = pos;
            rep.too_long        = (pos >= len_limit);
            in_line = 1'b0;
            return 1'b1;
        end
        if (pos >= 8'd1 && pos <= 8'(nsc_pkg::NAME_CHARS))
        begin
            for (int k = 0; k < nsc_pkg::NAME_COUNT; k++)
            begin
                if (b != talker_names[k][pos - 1])
                begin
                    name_hits[k] = 1'b0;
                end
            end
        end
        if (pos == nsc_pkg::GSV_PART_OFFSET)
        begin
            part_val = (b >= "0" && b <= "9") ? 4'(b - "0") : 4'd0;
        end
        if (pos == nsc_pkg::STATUS_OFFSET)
        begin
            status_ok = (b == nsc_pkg::CH_A);
        end
        unique case (sum_phase)
            nsc_pkg::PH_BEFORE_STAR:
            begin
                if (b == nsc_pkg::CH_STAR)
                begin
                    sum_phase = nsc_pkg::PH_HEX_HI;
                end
                else
                begin
                    run_xor = run_xor ^ b;
                end
            end
            nsc_pkg::PH_HEX_HI:
            begin
                got_sum   = {hex_digit(b), 4'd0};
                sum_phase = nsc_pkg::PH_HEX_LO;
            end
            nsc_pkg::PH_HEX_LO:
            begin
                got_sum[3:0] = hex_digit(b);
                sum_phase    = nsc_pkg::PH_DONE;
            end
            default:
            begin
            end
        endcase
        line_pos = (pos < nsc_pkg::POS_MAX) ? pos + 8'd1 : nsc_pkg::POS_MAX;
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Byte sender: bursts of random length with random gaps between them
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, output bit closed, output sentence_report_t rep);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        closed = parse_byte(b, rep);
        burst_left--;
        bytes_sent++;
    endtask

    // Directed byte: a typed row supplies its own report, others use the shadow parser
    task automatic directed_byte(input logic [7:0] b, input plan_row_t row);
        bit               closed;
        sentence_report_t rep;
        send_byte(b, closed, rep);
        if (closed)
        begin
            report_q.push_back(row.typed ? row.report : rep);
        end
    endtask

    // Sender holds off until every owed report has been taken
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (report_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_MAX_LEN)
        begin
            len_limit = data[7:0];
        end
    endtask

    // Read back the length limit and compare with the shadow copy
    task automatic check_limit_readback();
        logic [31:0] data;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_MAX_LEN;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (data[7:0] !== len_limit)
        begin
            $error("max_sentence_length: expected %0d, got %0d", len_limit, data[7:0]);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Random sentence: mostly well formed, with noise, bad names, bad sums,
    // truncation and overlong bodies mixed in
    // ------------------------------------------------------------------
    task automatic build_line();
        int         base;
        int         pick;
        int         name_len;
        int         body;
        int         sum_mode;
        logic [7:0] c;
        logic [7:0] sum;
        line_q.delete();
        // noise ahead of the '$' is ignored unless it opens a sentence itself
        if ($urandom_range(0, 6) == 0)
        begin
            repeat ($urandom_range(1, 4)) line_q.push_back(8'($urandom_range(0, 255)));
        end
        base = line_q.size();
        line_q.push_back(nsc_pkg::CH_DOLLAR);
        pick     = $urandom_range(0, 9);
        name_len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 4) : nsc_pkg::NAME_CHARS;
        for (int k = 0; k < name_len; k++)
        begin
            if (pick < nsc_pkg::NAME_COUNT)
            begin
                c = talker_names[pick][k];
            end
            else if (k < 3 && $urandom_range(0, 1) == 1)
            begin
                c = talker_names[nsc_pkg::NAME_COUNT - 1][k];   // near miss on the name
            end
            else
            begin
                c = 8'($urandom_range(65, 90));
            end
            line_q.push_back(c);
        end
        body = ($urandom_range(0, 40) == 0) ? $urandom_range(60, 270) : $urandom_range(0, 28);
        repeat (body)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                c = 8'($urandom_range(0, 255));
            end
            else
            begin
                c = 8'($urandom_range(32, 126));
                if (c == nsc_pkg::CH_STAR || c == nsc_pkg::CH_DOLLAR)
                begin
                    c = ",";
                end
            end
            line_q.push_back(c);
        end
        // GSV part digit and RMC status byte at their fixed offsets
        if (base + nsc_pkg::GSV_PART_OFFSET < line_q.size() && $urandom_range(0, 4) != 0)
        begin
            line_q[base + nsc_pkg::GSV_PART_OFFSET] = "0" + 8'($urandom_range(0, 9));
        end
        if (base + nsc_pkg::STATUS_OFFSET < line_q.size())
        begin
            line_q[base + nsc_pkg::STATUS_OFFSET] =
                ($urandom_range(0, 2) != 0) ? nsc_pkg::CH_A : "V";
        end
        sum = 8'd0;
        for (int k = base + 1; k < line_q.size(); k++)
        begin
            sum = sum ^ line_q[k];
        end
        sum_mode = $urandom_range(0, 9);
        if (sum_mode < 8)
        begin
            line_q.push_back(nsc_pkg::CH_STAR);
            if (sum_mode == 6)
            begin
                sum = sum ^ 8'($urandom_range(1, 255));
            end
            if (sum_mode < 7)
            begin
                line_q.push_back(hex_char(sum[7:4]));
                line_q.push_back(hex_char(sum[3:0]));
            end
            else
            begin
                // lowercase, non-hex or missing digits
                repeat ($urandom_range(0, 2)) line_q.push_back(8'($urandom_range(32, 126)));
            end
            if ($urandom_range(0, 7) == 0)
            begin
                line_q.push_back(nsc_pkg::CH_STAR);
                line_q.push_back(8'($urandom_range(32, 126)));
            end
        end
        // a dropped line feed leaves the sentence open for the next '$' to discard
        if ($urandom_range(0, 12) != 0)
        begin
            line_q.push_back(nsc_pkg::CH_LF);
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    plan_row_t plan [16] = '{
        // line feed outside a sentence: no report
        '{"", 0, 1'b0, '0},
        // empty sentence
        '{"$", 0, 1'b1, '{nsc_pkg::TYPE_UNKNOWN, 1'b0, 4'd0, 1'b0, 8'd1, 1'b0}},
        // name cut short before offset 6
        '{"$GPGG", 0, 1'b1, '{nsc_pkg::TYPE_UNKNOWN, 1'b0, 4'd0, 1'b0, 8'd5, 1'b0}},
        // '$' restarts a partial sentence
        '{"$GP$GPVTG", 0, 1'b1, '{nsc_pkg::TYPE_VTG, 1'b0, 4'd0, 1'b0, 8'd6, 1'b0}},
        '{"$GPGGA*56", 0, 1'b0, '0},
        // non-hex checksum digits
        '{"$GPGSA*zz", 0, 1'b0, '0},
        // star with both digits missing: empty XOR matches zero
        '{"$*", 0, 1'b1, '{nsc_pkg::TYPE_UNKNOWN, 1'b1, 4'd0, 1'b0, 8'd2, 1'b0}},
        '{"$GPGSV,3,2,11*7A", 0, 1'b0, '0},
        '{"$GPGSV,3,9,X", 0, 1'b0, '0},
        // GSV part byte that is not a digit
        '{"$GPGSV,3,Q", 0, 1'b0, '0},
        '{"$GPRMC,123519.000,A,*4F", 0, 1'b0, '0},
        '{"$GPRMC,123519.000,V", 0, 1'b0, '0},
        // bytes and a second star after the checksum
        '{"$GPVTG*4C**x*", 0, 1'b0, '0},
        // just below, at, and far past the default length limit
        '{"$", 81, 1'b1, '{nsc_pkg::TYPE_UNKNOWN, 1'b0, 4'd0, 1'b0, 8'd82, 1'b0}},
        '{"$", 82, 1'b1, '{nsc_pkg::TYPE_UNKNOWN, 1'b0, 4'd0, 1'b0, 8'd83, 1'b1}},
        '{"$", 299, 1'b1, '{nsc_pkg::TYPE_UNKNOWN, 1'b0, 4'd0, 1'b0, 8'd255, 1'b1}}
    };

    // ------------------------------------------------------------------
    // Result side: stall pattern and scoreboard
    // ------------------------------------------------------------------
    int stall_mode;
    int stall_left;

    // The receiver switches between stall densities on its own schedule
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        sentence_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            reports_seen++;
            if (report_q.size() == 0)
            begin
                $error("report transfer with nothing owed: type %0d length %0d",
                       sentence_type, sentence_length);
                errors++;
            end
            else
            begin
                want = report_q.pop_front();
                if (sentence_type !== want.sentence_type)
                begin
                    $error("sentence_type: expected %0d, got %0d",
                           want.sentence_type, sentence_type);
                    errors++;
                end
                if (checksum_ok !== want.checksum_ok)
                begin
                    $error("checksum_ok: expected %0d, got %0d", want.checksum_ok, checksum_ok);
                    errors++;
                end
                if (gsv_part !== want.gsv_part)
                begin
                    $error("gsv_part: expected %0d, got %0d", want.gsv_part, gsv_part);
                    errors++;
                end
                if (fix_valid !== want.fix_valid)
                begin
                    $error("fix_valid: expected %0d, got %0d", want.fix_valid, fix_valid);
                    errors++;
                end
                if (sentence_length !== want.sentence_length)
                begin
                    $error("sentence_length: expected %0d, got %0d",
                           want.sentence_length, sentence_length);
                    errors++;
                end
                if (too_long !== want.too_long)
                begin
                    $error("too_long: expected %0d, got %0d", want.too_long, too_long);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        bit               closed;
        sentence_report_t rep;
        logic [7:0]       limits [6];

        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        rx_byte    = '0;
        out_stall  = 1'b0;
        stall_mode = 0;
        stall_left = 0;
        errors     = 0;
        bytes_sent = 0;
        reports_seen  = 0;
        settings_done = 1;
        burst_left = 0;

        // shadow parser after reset
        len_limit = nsc_pkg::MAX_LEN_RESET;
        start_line();
        in_line  = 1'b0;
        line_pos = 8'd0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of the register, then byte extremes outside any sentence
        check_limit_readback();
        send_byte(8'h00, closed, rep);
        send_byte(8'hFF, closed, rep);

        foreach (plan[i])
        begin
            for (int j = 0; j < plan[i].head.len(); j++)
            begin
                directed_byte(plan[i].head[j], plan[i]);
            end
            repeat (plan[i].fill) directed_byte("X", plan[i]);
            directed_byte(nsc_pkg::CH_LF, plan[i]);
        end

        // register extremes, a zero limit, a random one, and back to the default
        limits = '{8'd255, 8'd8, 8'd0, 8'($urandom_range(8, 255)), 8'd1,
                   nsc_pkg::MAX_LEN_RESET};
        foreach (limits[p])
        begin
            wait_drained();
            repeat (PIPE_SETTLE) @(posedge clk);
            if (p == 1)
            begin
                // an undecoded address must leave the limit alone
                apb_write(ADDR_UNUSED, 32'($urandom()));
                check_limit_readback();
            end
            apb_write(ADDR_MAX_LEN, {24'd0, limits[p]});
            check_limit_readback();
            settings_done++;
            for (int n = 0; n < PHASE_BYTES; n += line_q.size())
            begin
                build_line();
                foreach (line_q[k])
                begin
                    send_byte(line_q[k], closed, rep);
                    if (closed)
                    begin
                        report_q.push_back(rep);
                    end
                end
                if ($urandom_range(0, 24) == 0)
                begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Covered %0d byte transfers and %0d sentence reports", bytes_sent, reports_seen);
        $display("across %0d length limit settings, extremes and a zero limit included",
                 settings_done);
        if (errors == 0)
        begin
            $display("nmea_sentence_checker test passed");
        end
        else
        begin
            $display("nmea_sentence_checker test failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("nmea_sentence_checker test failed");
        $finish;
    end

endmodule

[nmea_sentence_checker.f]
+incdir+design
design/nsc_pkg.sv
design/nsc_in_stage.sv
design/nsc_parser.sv
design/nsc_out_stage.sv
design/nmea_sentence_checker.sv
tb/nmea_sentence_checker_tb.sv
